FILE: hw/rtl/xld_pkg.sv
// types and constants shared by the xiph lacing deframer
`default_nettype none

package xld_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } xld_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  item_kind;
        logic [7:0]  segment_index;
        logic        segment_start;
        logic        segment_end;
        logic [15:0] segment_length;
        logic [15:0] byte_position;
        logic        in_wanted;
        logic        buffer_end;
        logic [2:0]  status;
    } xld_result_t;

    typedef enum logic [3:0] {
        PH_COUNT   = 4'b0001,
        PH_LACE    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DISCARD = 4'b1000
    } xld_phase_t;

    localparam logic [1:0] KIND_COUNT   = 2'd0;
    localparam logic [1:0] KIND_LACE    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_LACE_TRUNC  = 3'd1;
    localparam logic [2:0] ST_SEG_TRUNC   = 3'd2;
    localparam logic [2:0] ST_EMPTY_LAST  = 3'd3;
    localparam logic [2:0] ST_INDEX_RANGE = 3'd4;
    localparam logic [2:0] ST_OVERFLOW    = 3'd5;

    localparam logic [7:0]  LACE_CONTINUE = 8'd255;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/xiph_lacing_deframer_unit.sv
// xiph lacing deframer: tags every byte of a laced header buffer
//
// item channel (item_valid / item_stall / item) takes one buffer byte per
// request, with end_of_buffer set on the last byte. result channel
// (result_valid / result_stall / result) returns exactly one tagged
// request per byte, in order: the byte, its kind, its segment, start and
// end marks, segment length, position, wanted flag and, on the last byte,
// the status of the whole buffer.
// each result is registered when its byte is taken, into the skid stage if stalled
// throughput: one byte per cycle while item_stall is low. a byte that closes
// a non-final segment is held until the look-ahead scan over the lace length
// memory has found the following segment; the scan reads one entry per
// cycle, stepping over zero-length segments, and stops at the final segment
// when no segment before it carries bytes
// cfg_we / cfg_data write the wanted segment index; write only when idle
// reset clears the walk state and the wanted index; the length memory is
// not cleared, as each buffer writes its entries before reading them
// a stalled receiver is absorbed by an output register plus one skid
// stage; item_stall rises once both are full
`default_nettype none

module xiph_lacing_deframer_unit #(
    parameter int LENGTH_WIDTH = 16,
    parameter int MAX_SEGMENTS = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire xld_pkg::xld_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output xld_pkg::xld_result_t     result,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_data
);

    import xld_pkg::*;

    localparam int LW     = LENGTH_WIDTH;
    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    // clamp a length to the 16-bit result field
    function automatic logic [15:0] clamp16(input logic [LW-1:0] v);
        logic [LW+15:0] w;
        w = {16'b0, v};
        if (w[LW+15:16] != '0)
            return 16'hFFFF;
        return w[15:0];
    endfunction

    // lace length memory
    logic [LW-1:0]     len_mem [0:MAX_SEGMENTS-1];
    logic [LW-1:0]     rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [LW-1:0]     mem_wdata;
    logic              rd_en;

    // walk state
    xld_phase_t    phase_reg, phase_next;
    logic [7:0]    count_m1_reg, count_m1_next;
    logic [7:0]    lace_index_reg, lace_index_next;
    logic [LW-1:0] lace_accum_reg, lace_accum_next;
    logic [7:0]    cur_seg_reg, cur_seg_next;
    logic [LW-1:0] cur_len_reg, cur_len_next;
    logic [LW-1:0] bytes_left_reg, bytes_left_next;
    logic [15:0]   position_reg, position_next;
    logic          overflow_reg, overflow_next;
    logic          first_found_reg, first_found_next;
    logic [7:0]    first_seg_reg, first_seg_next;
    logic [LW-1:0] first_len_reg, first_len_next;

    // look-ahead scan state
    logic          scan_on_reg, scan_on_next;
    logic [7:0]    scan_ptr_reg, scan_ptr_next;
    logic          rd_pending_reg, rd_pending_next;
    logic [7:0]    rd_idx_reg, rd_idx_next;
    logic          ahead_valid_reg, ahead_valid_next;
    logic [7:0]    ahead_seg_reg, ahead_seg_next;
    logic [LW-1:0] ahead_len_reg, ahead_len_next;

    logic [7:0]    wanted_reg;

    // output register and skid stage
    logic          out_valid_reg, skid_valid_reg;
    xld_result_t   out_reg, skid_reg;

    logic          busy;
    logic          accept;
    logic          out_fire;
    logic          cur_nonfinal;
    xld_result_t   res;

    // helper values
    logic [LW:0]   lace_sum;
    logic [LW:0]   final_sum;
    logic [7:0]    enter_seg;
    logic [LW-1:0] enter_len;
    logic [2:0]    code;
    logic [7:0]    count_m1_now;

    assign cur_nonfinal = (cur_seg_reg < count_m1_reg);
    // a segment-closing byte needs the following segment known
    assign busy = (phase_reg == PH_PAYLOAD) && cur_nonfinal
                  && (bytes_left_reg == LW'(1)) && !ahead_valid_reg;
    assign item_stall = busy || skid_valid_reg;
    assign accept     = item_valid && !item_stall;
    assign out_fire   = out_valid_reg && !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign lace_sum  = {1'b0, lace_accum_reg} + (LW+1)'(item.byte_in);
    assign final_sum = {1'b0, bytes_left_reg} + (LW+1)'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        count_m1_next    = count_m1_reg;
        lace_index_next  = lace_index_reg;
        lace_accum_next  = lace_accum_reg;
        cur_seg_next     = cur_seg_reg;
        cur_len_next     = cur_len_reg;
        bytes_left_next  = bytes_left_reg;
        position_next    = position_reg;
        overflow_next    = overflow_reg;
        first_found_next = first_found_reg;
        first_seg_next   = first_seg_reg;
        first_len_next   = first_len_reg;
        scan_on_next     = scan_on_reg;
        scan_ptr_next    = scan_ptr_reg;
        rd_pending_next  = 1'b0;
        rd_idx_next      = rd_idx_reg;
        ahead_valid_next = ahead_valid_reg;
        ahead_seg_next   = ahead_seg_reg;
        ahead_len_next   = ahead_len_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = lace_index_reg[ADDR_W-1:0];
        mem_wdata        = lace_sum[LW-1:0];
        enter_seg        = first_seg_reg;
        enter_len        = first_len_reg;
        code             = ST_OK;
        count_m1_now     = count_m1_reg;
        res              = '0;

        // background scan for the next segment with bytes
        if (scan_on_reg && !ahead_valid_reg)
        begin
            if (rd_pending_reg && (rd_data_reg != '0))
            begin
                ahead_valid_next = 1'b1;
                ahead_seg_next   = rd_idx_reg;
                ahead_len_next   = rd_data_reg;
                scan_on_next     = 1'b0;
            end
            else if (scan_ptr_reg < count_m1_reg)
            begin
                rd_en           = 1'b1;
                rd_idx_next     = scan_ptr_reg;
                scan_ptr_next   = scan_ptr_reg + 8'd1;
                rd_pending_next = 1'b1;
            end
            else
            begin
                // nothing left but the final segment
                ahead_valid_next = 1'b1;
                ahead_seg_next   = count_m1_reg;
                ahead_len_next   = '0;
                scan_on_next     = 1'b0;
            end
        end

        res.byte_out      = item.byte_in;
        res.byte_position = position_reg;
        res.buffer_end    = item.end_of_buffer;

        if (accept)
        begin
            if ((position_reg == POS_MAX) && !item.end_of_buffer)
                overflow_next = 1'b1;
            position_next = (position_reg == POS_MAX) ? position_reg
                                                      : position_reg + 16'd1;

            unique case (phase_reg)
                PH_COUNT:
                begin
                    res.item_kind    = KIND_COUNT;
                    count_m1_next    = item.byte_in;
                    count_m1_now     = item.byte_in;
                    first_found_next = 1'b0;
                    if ({1'b0, item.byte_in} >= 9'(MAX_SEGMENTS))
                    begin
                        phase_next = PH_DISCARD;
                        code       = ST_OVERFLOW;
                    end
                    else if (item.byte_in == 8'd0)
                    begin
                        cur_seg_next    = '0;
                        bytes_left_next = '0;
                        phase_next      = PH_PAYLOAD;
                        code            = ST_EMPTY_LAST;
                    end
                    else
                    begin
                        lace_index_next = '0;
                        lace_accum_next = '0;
                        phase_next      = PH_LACE;
                        code            = ST_LACE_TRUNC;
                    end
                end
                PH_LACE:
                begin
                    res.item_kind = KIND_LACE;
                    code          = ST_LACE_TRUNC;
                    if (lace_sum[LW])
                        overflow_next = 1'b1;
                    mem_wdata       = lace_sum[LW] ? LEN_MAX : lace_sum[LW-1:0];
                    lace_accum_next = mem_wdata;
                    if (item.byte_in != LACE_CONTINUE)
                    begin
                        mem_we          = 1'b1;
                        lace_index_next = lace_index_reg + 8'd1;
                        lace_accum_next = '0;
                        // track the first segment that carries bytes
                        if (!first_found_reg && (mem_wdata != '0))
                        begin
                            first_found_next = 1'b1;
                            first_seg_next   = lace_index_reg;
                            first_len_next   = mem_wdata;
                        end
                        if ((lace_index_reg + 8'd1) == count_m1_reg)
                        begin
                            if (first_found_reg)
                            begin
                                enter_seg = first_seg_reg;
                                enter_len = first_len_reg;
                            end
                            else if (mem_wdata != '0)
                            begin
                                enter_seg = lace_index_reg;
                                enter_len = mem_wdata;
                            end
                            else
                            begin
                                enter_seg = count_m1_reg;
                                enter_len = '0;
                            end
                            phase_next       = PH_PAYLOAD;
                            cur_seg_next     = enter_seg;
                            ahead_valid_next = 1'b0;
                            rd_pending_next  = 1'b0;
                            if (enter_seg < count_m1_reg)
                            begin
                                cur_len_next    = enter_len;
                                bytes_left_next = enter_len;
                                scan_on_next    = 1'b1;
                                scan_ptr_next   = enter_seg + 8'd1;
                                code            = ST_SEG_TRUNC;
                            end
                            else
                            begin
                                bytes_left_next = '0;
                                scan_on_next    = 1'b0;
                                code            = ST_EMPTY_LAST;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res.item_kind     = KIND_PAYLOAD;
                    res.segment_index = cur_seg_reg;
                    res.in_wanted     = (cur_seg_reg == wanted_reg);
                    if (cur_nonfinal)
                    begin
                        res.segment_length = clamp16(cur_len_reg);
                        res.segment_start  = (bytes_left_reg == cur_len_reg);
                        res.segment_end    = (bytes_left_reg == LW'(1));
                        code               = ST_SEG_TRUNC;
                        if (bytes_left_reg == LW'(1))
                        begin
                            // step to the segment found by the scan
                            cur_seg_next     = ahead_seg_reg;
                            ahead_valid_next = 1'b0;
                            rd_pending_next  = 1'b0;
                            if (ahead_seg_reg < count_m1_reg)
                            begin
                                cur_len_next    = ahead_len_reg;
                                bytes_left_next = ahead_len_reg;
                                scan_on_next    = 1'b1;
                                scan_ptr_next   = ahead_seg_reg + 8'd1;
                            end
                            else
                            begin
                                bytes_left_next = '0;
                                scan_on_next    = 1'b0;
                                code            = ST_EMPTY_LAST;
                            end
                        end
                        else
                            bytes_left_next = bytes_left_reg - LW'(1);
                    end
                    else
                    begin
                        res.segment_start = (bytes_left_reg == '0);
                        res.segment_end   = item.end_of_buffer;
                        if (final_sum[LW])
                            overflow_next = 1'b1;
                        bytes_left_next    = final_sum[LW] ? LEN_MAX : final_sum[LW-1:0];
                        res.segment_length = clamp16(bytes_left_next);
                        code               = ST_OK;
                    end
                end
                PH_DISCARD:
                begin
                    res.item_kind = KIND_LACE;
                    code          = ST_OVERFLOW;
                end
                default:
                begin
                    res.item_kind = KIND_LACE;
                    code          = ST_OVERFLOW;
                end
            endcase

            if (item.end_of_buffer)
            begin
                if (wanted_reg > count_m1_now)
                    res.status = ST_INDEX_RANGE;
                else if (overflow_next)
                    res.status = ST_OVERFLOW;
                else
                    res.status = code;

                // back to the start state for the next buffer
                phase_next       = PH_COUNT;
                count_m1_next    = '0;
                lace_index_next  = '0;
                lace_accum_next  = '0;
                cur_seg_next     = '0;
                bytes_left_next  = '0;
                position_next    = '0;
                overflow_next    = 1'b0;
                first_found_next = 1'b0;
                scan_on_next     = 1'b0;
                rd_pending_next  = 1'b0;
                ahead_valid_next = 1'b0;
            end
        end
    end

    // memory port: one write from the lace walk, one read for the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
            len_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= len_mem[scan_ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COUNT;
            count_m1_reg    <= '0;
            lace_index_reg  <= '0;
            lace_accum_reg  <= '0;
            cur_seg_reg     <= '0;
            cur_len_reg     <= '0;
            bytes_left_reg  <= '0;
            position_reg    <= '0;
            overflow_reg    <= 1'b0;
            first_found_reg <= 1'b0;
            first_seg_reg   <= '0;
            first_len_reg   <= '0;
            scan_on_reg     <= 1'b0;
            scan_ptr_reg    <= '0;
            rd_pending_reg  <= 1'b0;
            rd_idx_reg      <= '0;
            ahead_valid_reg <= 1'b0;
            ahead_seg_reg   <= '0;
            ahead_len_reg   <= '0;
            wanted_reg      <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            count_m1_reg    <= count_m1_next;
            lace_index_reg  <= lace_index_next;
            lace_accum_reg  <= lace_accum_next;
            cur_seg_reg     <= cur_seg_next;
            cur_len_reg     <= cur_len_next;
            bytes_left_reg  <= bytes_left_next;
            position_reg    <= position_next;
            overflow_reg    <= overflow_next;
            first_found_reg <= first_found_next;
            first_seg_reg   <= first_seg_next;
            first_len_reg   <= first_len_next;
            scan_on_reg     <= scan_on_next;
            scan_ptr_reg    <= scan_ptr_next;
            rd_pending_reg  <= rd_pending_next;
            rd_idx_reg      <= rd_idx_next;
            ahead_valid_reg <= ahead_valid_next;
            ahead_seg_reg   <= ahead_seg_next;
            ahead_len_reg   <= ahead_len_next;
            if (cfg_we)
                wanted_reg <= cfg_data;

            if (accept)
            begin
                if (out_valid_reg && !out_fire)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= res;
            else
                out_reg <= res;
        end
        else if (out_fire && skid_valid_reg)
            out_reg <= skid_reg;
    end

endmodule

`default_nettype wire
